[rtl/mshp_pkg.sv]
// ----------------------------------------------------------------------------
// mshp_pkg
// Shared constants and payload types for the min-max hypergraph partitioner.
// ----------------------------------------------------------------------------
package mshp_pkg;
	localparam int PARTS      = 16;
	localparam int PART_W     = 4;
	localparam int EDGE_W     = 12;
	localparam int NUM_EDGES  = 4096;
	localparam int MAX_DEG    = 64;
	localparam int DEG_W      = 6;
	localparam int CNT_W      = 7;
	localparam int LOAD_W     = 17;
	localparam int HIT_W      = 8;
	localparam int VID_W      = 16;
	localparam int SLACK_W    = 16;
	localparam logic [LOAD_W-1:0] LOAD_MAX = '1;
	localparam logic [HIT_W-1:0]  HIT_MAX  = '1;

	typedef struct packed {
		logic [VID_W-1:0]  vertex_id;
		logic [EDGE_W-1:0] edge_id;
		logic              edge_valid;
		logic              last;
	} in_item_t;

	typedef struct packed {
		logic [VID_W-1:0]  placed_vertex;
		logic [PART_W-1:0] partition;
		logic              degree_overflow;
	} out_item_t;
endpackage

[rtl/mshp_in_if.sv]
// ----------------------------------------------------------------------------
// mshp_in_if
// Valid/ready channel carrying one edge item.
// ----------------------------------------------------------------------------
interface mshp_in_if import mshp_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/mshp_out_if.sv]
// ----------------------------------------------------------------------------
// mshp_out_if
// Valid/ready channel carrying one placement result.
// ----------------------------------------------------------------------------
interface mshp_out_if import mshp_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/minmax_stream_hypergraph_partition.sv]
// ----------------------------------------------------------------------------
// minmax_stream_hypergraph_partition
// Streaming min-max partitioner: one membership read per edge, write-back on close.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 4096-entry membership memory to zero,
// taking no input meanwhile. Each edge transfer does a membership-memory read,
// then the hit update. A closing item then runs the load-bounded pick over the
// 16 partitions, the load update, one read-modify-write of the membership
// memory per edge in the 64-entry pending buffer, the least-loaded rescan (over all
// 16 partitions when the winner was the least loaded, skipped otherwise), and
// the hand-off of the result to the output register, which waits while that
// register still holds an untaken result. The next vertex starts while the
// result waits.
module minmax_stream_hypergraph_partition import mshp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [SLACK_W-1:0] cfg_wdata,
	mshp_in_if.sink            in_ch,
	mshp_out_if.source         out_ch
);
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_HIT, S_PICK, S_WRD, S_WWR, S_LOAD, S_SCAN, S_PUSH
	} state_t;

	state_t state_q;
	logic [SLACK_W-1:0] slack_q;
	logic [PARTS-1:0]   mem [NUM_EDGES];
	logic [PARTS-1:0]   rd_q;
	logic [EDGE_W-1:0]  pend [MAX_DEG];
	logic [EDGE_W-1:0]  pend_rd_q;
	logic [LOAD_W-1:0]  load_q [PARTS];
	logic [HIT_W-1:0]   hit_q [PARTS];
	logic [PART_W-1:0]  least_q, best_q, idx_q;
	logic [HIT_W:0]     best_hits_q;
	logic [LOAD_W-1:0]  base_q;
	logic [CNT_W-1:0]   cnt_q, k_q;
	logic               ovf_q, valid_q, last_q, won_least_q;
	logic [VID_W-1:0]   vid_q;
	logic [EDGE_W-1:0]  eid_q, clr_q;
	logic               o_valid_q;
	out_item_t          o_data_q;

	logic [LOAD_W-1:0] ld_i;
	logic              allowed;
	assign ld_i    = load_q[idx_q];
	assign allowed = !(ld_i > base_q) ||
		({{(LOAD_W-SLACK_W){1'b0}}, slack_q} >= ld_i - base_q);

	assign in_ch.ready  = (state_q == S_IDLE);
	assign out_ch.valid = o_valid_q;
	assign out_ch.data  = o_data_q;

	// Membership memory: one read port, one write port
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) begin
			mem[clr_q] <= '0;
		end else if (state_q == S_WWR) begin
			mem[eid_q] <= rd_q | (PARTS'(1) << best_q);
		end
		if (state_q == S_IDLE) begin
			rd_q <= mem[in_ch.data.edge_id];
		end else if (state_q == S_WRD) begin
			rd_q <= mem[pend_rd_q];
		end
	end

	// Pending edge buffer
	always_ff @(posedge clk) begin
		if (state_q == S_HIT && valid_q && !cnt_q[DEG_W]) begin
			pend[cnt_q[DEG_W-1:0]] <= eid_q;
		end
		pend_rd_q <= pend[k_q[DEG_W-1:0]];
	end

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slack_q <= '0;
		end else if (cfg_we) begin
			slack_q <= cfg_wdata;
		end
	end

	// Control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			least_q     <= '0;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			o_valid_q   <= 1'b0;
			k_q         <= '0;
			idx_q       <= '0;
			best_q      <= '0;
			best_hits_q <= '0;
			won_least_q <= 1'b0;
			for (int i = 0; i < PARTS; i++) begin
				load_q[i] <= '0;
				hit_q[i]  <= '0;
			end
		end else begin
			if (out_ch.valid && out_ch.ready && state_q != S_PUSH) begin
				o_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == EDGE_W'(NUM_EDGES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_ch.valid) begin
						vid_q   <= in_ch.data.vertex_id;
						eid_q   <= in_ch.data.edge_id;
						valid_q <= in_ch.data.edge_valid;
						last_q  <= in_ch.data.last;
						state_q <= S_HIT;
					end
				end
				S_HIT: begin
					if (valid_q) begin
						for (int i = 0; i < PARTS; i++) begin
							if (rd_q[i] && hit_q[i] != HIT_MAX) hit_q[i] <= hit_q[i] + 1'b1;
						end
						if (!cnt_q[DEG_W]) cnt_q <= cnt_q + 1'b1;
						else ovf_q <= 1'b1;
					end
					if (last_q) begin
						base_q      <= load_q[least_q];
						idx_q       <= '0;
						best_hits_q <= '0;
						best_q      <= '0;
						state_q     <= S_PICK;
					end else begin
						state_q <= S_IDLE;
					end
				end
				// one partition per cycle; first allowed one always wins over -1
				S_PICK: begin
					if (allowed && ({1'b0, hit_q[idx_q]} >= best_hits_q ||
							best_hits_q[HIT_W])) begin
						best_q      <= idx_q;
						best_hits_q <= {1'b0, hit_q[idx_q]};
					end
					if (idx_q == 0 && !allowed) best_hits_q <= {1'b1, {HIT_W{1'b0}}};
					idx_q <= idx_q + 1'b1;
					if (idx_q == PART_W'(PARTS - 1)) begin
						k_q     <= '0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (load_q[best_q] != LOAD_MAX) load_q[best_q] <= load_q[best_q] + 1'b1;
					won_least_q <= (best_q == least_q);
					idx_q       <= '0;
					state_q     <= (cnt_q != 0) ? S_WRD : S_SCAN;
				end
				S_WRD: begin
					eid_q   <= pend_rd_q;
					k_q     <= k_q + 1'b1;
					state_q <= S_WWR;
				end
				S_WWR: begin
					state_q <= (k_q == cnt_q) ? S_SCAN : S_WRD;
				end
				S_SCAN: begin
					if (won_least_q) begin
						if (load_q[idx_q] < load_q[least_q]) least_q <= idx_q;
						idx_q <= idx_q + 1'b1;
					end
					if (!won_least_q || idx_q == PART_W'(PARTS - 1)) state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (!o_valid_q || out_ch.ready) begin
						o_valid_q                <= 1'b1;
						o_data_q.placed_vertex   <= vid_q;
						o_data_q.partition       <= best_q;
						o_data_q.degree_overflow <= ovf_q;
						for (int i = 0; i < PARTS; i++) hit_q[i] <= '0;
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[rtl/mshp_checker.sv]
// ----------------------------------------------------------------------------
// mshp_checker
// Port-level checks for the partitioner, bound to the top level.
// ----------------------------------------------------------------------------
module mshp_checker import mshp_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      in_last,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);
	// a result stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped or changed while stalled");
	// input is never taken back to back
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on consecutive cycles");
	// a closing item yields no result in the very next cycle
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !$rose(out_valid))
		else $error("result too early");
endmodule

bind minmax_stream_hypergraph_partition mshp_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_last(in_ch.data.last),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

[tb/mshp_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mshp_tb_pkg
// Placement predictor and result scoreboard for the hypergraph partitioner test.
// ----------------------------------------------------------------------------
package mshp_tb_pkg;
	import mshp_pkg::*;

	class placement_board;
		logic [PARTS-1:0]  member [NUM_EDGES];
		logic [LOAD_W-1:0] load [PARTS];
		logic [PART_W-1:0] min_idx;
		logic [HIT_W-1:0]  hits [PARTS];
		logic [EDGE_W-1:0] pend [MAX_DEG];
		int                pend_cnt;
		bit                ovf;
		logic [SLACK_W-1:0] slack;
		out_item_t         placements [$];
		int                errors;

		function new();
			foreach (member[i]) member[i] = '0;
			foreach (load[i]) load[i] = '0;
			foreach (hits[i]) hits[i] = '0;
			min_idx = '0;
			pend_cnt = 0;
			ovf = 0;
			slack = '0;
			errors = 0;
		endfunction

		// update state for one accepted input transfer
		function void note_input(in_item_t it);
			logic [LOAD_W-1:0] base;
			int best;
			int best_hits;
			out_item_t r;
			if (it.edge_valid) begin
				for (int i = 0; i < PARTS; i++)
					if (member[it.edge_id][i] && hits[i] != HIT_MAX) hits[i]++;
				if (pend_cnt < MAX_DEG) begin
					pend[pend_cnt] = it.edge_id;
					pend_cnt++;
				end else ovf = 1;
			end
			if (!it.last) return;
			// load-bounded pick, highest index wins ties
			base = load[min_idx];
			best = 0;
			best_hits = -1;
			for (int i = 0; i < PARTS; i++) begin
				if (load[i] > base && (load[i] - base) > slack) continue;
				if (int'(hits[i]) >= best_hits) begin
					best_hits = hits[i];
					best = i;
				end
			end
			for (int k = 0; k < pend_cnt; k++) member[pend[k]][best] = 1'b1;
			if (load[best] != LOAD_MAX) load[best]++;
			if (best == min_idx)
				for (int i = 0; i < PARTS; i++)
					if (load[i] < load[min_idx]) min_idx = PART_W'(i);
			r.placed_vertex = it.vertex_id;
			r.partition = PART_W'(best);
			r.degree_overflow = ovf;
			placements = {placements, r};
			foreach (hits[i]) hits[i] = '0;
			pend_cnt = 0;
			ovf = 0;
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		// compare one accepted result with the oldest expected placement
		task check_result(out_item_t got);
			out_item_t w;
			if (placements.size() == 0) begin
				report($sformatf("unexpected result vertex %0d", got.placed_vertex));
				return;
			end
			w = placements.pop_front();
			if (got.placed_vertex !== w.placed_vertex)
				report($sformatf("vertex got %0d want %0d", got.placed_vertex, w.placed_vertex));
			if (got.partition !== w.partition)
				report($sformatf("vertex %0d partition got %0d want %0d",
					w.placed_vertex, got.partition, w.partition));
			if (got.degree_overflow !== w.degree_overflow)
				report($sformatf("vertex %0d overflow got %0b want %0b",
					w.placed_vertex, got.degree_overflow, w.degree_overflow));
		endtask
	endclass
endpackage

[tb/minmax_stream_hypergraph_partition_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minmax_stream_hypergraph_partition_test
// Streams directed and random vertices through the partitioner under random
// idling on both channels and checks every placement against a predictor.
// ----------------------------------------------------------------------------
module minmax_stream_hypergraph_partition_test;
	import mshp_pkg::*;
	import mshp_tb_pkg::*;

	localparam int WATCHDOG = 20000;
	localparam int DRAIN = 300;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [SLACK_W-1:0] cfg_wdata = '0;
	bit calm = 0;
	int quiet = 0;

	mshp_in_if  in_ch ();
	mshp_out_if out_ch ();

	placement_board board;

	minmax_stream_hypergraph_partition dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always #1 clk = ~clk;

	initial begin
		in_ch.valid = 0;
		in_ch.data = '0;
		out_ch.ready = 0;
		board = new();
	end

	// sink side: random stalls, accepted transfers go to the board
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) board.check_result(out_ch.data);
			out_ch.ready <= calm || ($urandom_range(99) >= 35);
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// send one item, idling first at random
	task automatic send(input logic [15:0] vid, input logic [11:0] eid,
			input bit ev, input bit lst);
		in_item_t it;
		it.vertex_id = vid;
		it.edge_id = eid;
		it.edge_valid = ev;
		it.last = lst;
		while (!calm && $urandom_range(99) < 35) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data <= it;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		board.note_input(it);
	endtask

	// a vertex of deg valid edges drawn from a window of edge ids, or one invalid item when deg is zero
	task automatic send_vertex(input int deg, input int lo, input int span);
		logic [15:0] vid;
		vid = 16'($urandom);
		if (deg == 0) send(vid, 12'($urandom), 0, 1);
		else for (int k = 0; k < deg; k++)
			send(vid, 12'(lo + $urandom_range(span)), 1, k == deg - 1);
	endtask

	task automatic wait_idle();
		in_ch.valid <= 0;
		@(posedge clk);
		while (board.placements.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_slack(input logic [SLACK_W-1:0] v);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		board.slack = v;
		@(posedge clk);
	endtask

	initial begin
		int lo;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes, invalid items, repeats, overflow
		set_slack(16'd0);
		send(16'h0000, 12'h000, 1, 1);
		send(16'hFFFF, 12'hFFF, 1, 1);
		send(16'h1234, 12'hFFF, 0, 1);
		send(16'h0001, 12'h000, 1, 0);
		send(16'h0002, 12'h000, 1, 0);
		send(16'h0003, 12'h555, 0, 0);
		send(16'hAAAA, 12'hAAA, 1, 1);
		send(16'h5555, 12'h000, 1, 0);
		send(16'h5555, 12'h000, 0, 1);
		wait_idle();
		set_slack(16'hFFFF);
		send_vertex(70, 0, 7);
		send_vertex(3, 0, 3);
		send_vertex(0, 0, 0);
		wait_idle();
		// random phases over several slack settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_slack(16'd0);
				1: set_slack(16'd1);
				2: set_slack(16'hFFFF);
				3: set_slack(SLACK_W'($urandom_range(2, 8)));
				4: set_slack(SLACK_W'($urandom));
				default: set_slack(16'd0);
			endcase
			calm = (ph == 3);
			for (int v = 0; v < 44; v++) begin
				lo = (ph == 5) ? $urandom_range(4000) : $urandom_range(40);
				case ($urandom_range(19))
					0: send_vertex(0, 0, 0);
					1: send_vertex($urandom_range(65, 70), lo, 20);
					2: send(16'($urandom), 12'($urandom), 1'($urandom), 1'($urandom));
					default: send_vertex($urandom_range(1, 5), lo, 12);
				endcase
			end
			calm = 0;
			wait_idle();
		end
		if (board.errors == 0 && board.placements.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
